### rtl/core/pbc_pkg.sv
// Shared types, constants and CRC nibble tables for the packet block check core.
package pbc_pkg;

    localparam int unsigned PBC_MAX_RES    = 3;
    localparam int unsigned PBC_FIFO_DEPTH = 4;
    localparam int unsigned PBC_PTR_W      = $clog2(PBC_FIFO_DEPTH);
    localparam int unsigned PBC_CNT_W      = $clog2(PBC_FIFO_DEPTH + 1);
    localparam int unsigned PBC_NUM_W      = $clog2(PBC_MAX_RES + 1);

    localparam logic [7:0] PBC_CHAR_OFFSET = 8'h21;

    // check_type codes
    localparam logic [1:0] CHK_NONE  = 2'd0;
    localparam logic [1:0] CHK_SUM6  = 2'd1;
    localparam logic [1:0] CHK_SUM12 = 2'd2;
    localparam logic [1:0] CHK_CRC16 = 2'd3;

    // configuration register indexes
    localparam logic REG_CHECK_TYPE = 1'b0;
    localparam logic REG_SEVEN_BIT  = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic [7:0] check_char;
        logic       last_char;
    } t_out_word;

    // words produced by one accepted input word, w[0] goes out first
    typedef struct packed {
        logic [PBC_NUM_W-1:0]           num;
        t_out_word [PBC_MAX_RES-1:0]    w;
    } t_push;

    function automatic logic [15:0] crc_hi_nib(input logic [3:0] n);
        logic [15:0] v;
        case (n)
            4'd0:    v = 16'o000000;
            4'd1:    v = 16'o010201;
            4'd2:    v = 16'o020402;
            4'd3:    v = 16'o030603;
            4'd4:    v = 16'o041004;
            4'd5:    v = 16'o051205;
            4'd6:    v = 16'o061406;
            4'd7:    v = 16'o071607;
            4'd8:    v = 16'o102010;
            4'd9:    v = 16'o112211;
            4'd10:   v = 16'o122412;
            4'd11:   v = 16'o132613;
            4'd12:   v = 16'o143014;
            4'd13:   v = 16'o153215;
            4'd14:   v = 16'o163416;
            4'd15:   v = 16'o173617;
            default: v = 16'o000000;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] crc_lo_nib(input logic [3:0] n);
        logic [15:0] v;
        case (n)
            4'd0:    v = 16'o000000;
            4'd1:    v = 16'o010611;
            4'd2:    v = 16'o021422;
            4'd3:    v = 16'o031233;
            4'd4:    v = 16'o043044;
            4'd5:    v = 16'o053655;
            4'd6:    v = 16'o062466;
            4'd7:    v = 16'o072277;
            4'd8:    v = 16'o106110;
            4'd9:    v = 16'o116701;
            4'd10:   v = 16'o127532;
            4'd11:   v = 16'o137323;
            4'd12:   v = 16'o145154;
            4'd13:   v = 16'o155745;
            4'd14:   v = 16'o164576;
            4'd15:   v = 16'o174367;
            default: v = 16'o000000;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] encode6(input logic [5:0] v);
        return {2'b00, v} + PBC_CHAR_OFFSET;
    endfunction

endpackage

### rtl/core/pbc_check.sv
// Running sum / CRC-16 state, config registers and check character generation.
module pbc_check (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  pbc_pkg::t_in_word i_word,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [1:0]        i_cfg_data,
    output pbc_pkg::t_push    o_push
);
    import pbc_pkg::*;

    logic [1:0]  r_check_type;
    logic        r_seven_bit;
    logic [11:0] r_sum, n_sum;
    logic [15:0] r_crc, n_crc;
    logic        r_ended, n_ended;

    logic [7:0]  masked;
    logic [7:0]  crc_idx;
    logic [15:0] crc_upd;
    logic        take;
    logic [11:0] sum_upd;
    logic [15:0] crc_fin;
    logic [11:0] sum_fin;
    logic [5:0]  fold6;

    always_comb begin
        masked  = r_seven_bit ? {1'b0, i_word.data_byte[6:0]} : i_word.data_byte;
        crc_idx = r_crc[7:0] ^ masked;
        crc_upd = {8'h00, r_crc[15:8]} ^ crc_hi_nib(crc_idx[7:4]) ^ crc_lo_nib(crc_idx[3:0]);
        // a zero byte ends the packet; the full byte decides, not the masked one
        take    = !r_ended && (i_word.data_byte != 8'h00);
        sum_upd = r_sum + {4'h0, i_word.data_byte};
        sum_fin = take ? sum_upd : r_sum;
        crc_fin = take ? crc_upd : r_crc;
        fold6   = {4'h0, sum_fin[7:6]} + sum_fin[5:0];

        n_sum   = r_sum;
        n_crc   = r_crc;
        n_ended = r_ended;
        o_push  = '0;
        if (i_accept) begin
            if (i_word.last_byte) begin
                n_sum   = '0;
                n_crc   = '0;
                n_ended = 1'b0;
                case (r_check_type)
                    CHK_SUM6: begin
                        o_push.num = PBC_NUM_W'(1);
                        o_push.w[0] = '{check_char: encode6(fold6), last_char: 1'b1};
                    end
                    CHK_SUM12: begin
                        o_push.num = PBC_NUM_W'(2);
                        o_push.w[0] = '{check_char: encode6(sum_fin[11:6]), last_char: 1'b0};
                        o_push.w[1] = '{check_char: encode6(sum_fin[5:0]), last_char: 1'b1};
                    end
                    CHK_CRC16: begin
                        o_push.num = PBC_NUM_W'(3);
                        o_push.w[0] = '{check_char: encode6({2'b00, crc_fin[15:12]}),
                                        last_char: 1'b0};
                        o_push.w[1] = '{check_char: encode6(crc_fin[11:6]), last_char: 1'b0};
                        o_push.w[2] = '{check_char: encode6(crc_fin[5:0]), last_char: 1'b1};
                    end
                    default: begin
                        o_push.num = '0;
                    end
                endcase
            end else begin
                n_sum   = sum_fin;
                n_crc   = crc_fin;
                n_ended = r_ended | (i_word.data_byte == 8'h00);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check_type <= CHK_SUM6;
            r_seven_bit  <= 1'b0;
            r_sum        <= '0;
            r_crc        <= '0;
            r_ended      <= 1'b0;
        end else begin
            r_sum   <= n_sum;
            r_crc   <= n_crc;
            r_ended <= n_ended;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_CHECK_TYPE: r_check_type <= i_cfg_data;
                    REG_SEVEN_BIT:  r_seven_bit  <= i_cfg_data[0];
                    default:        r_seven_bit  <= r_seven_bit;
                endcase
            end
        end
    end

endmodule

### rtl/core/pbc_fifo.sv
// Small result queue taking up to three check words per cycle, draining one.
module pbc_fifo (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  pbc_pkg::t_push                   i_push,
    input  logic                             i_pop,
    output pbc_pkg::t_out_word               o_word,
    output logic                             o_valid,
    output logic [pbc_pkg::PBC_CNT_W-1:0]    o_count
);
    import pbc_pkg::*;

    t_out_word             r_mem [PBC_FIFO_DEPTH];
    logic [PBC_PTR_W-1:0]  r_rd;
    logic [PBC_PTR_W-1:0]  r_wr;
    logic [PBC_CNT_W-1:0]  r_count;

    assign o_word  = r_mem[r_rd];
    assign o_valid = (r_count != '0);
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < PBC_MAX_RES; k++) begin
            if (PBC_NUM_W'(k) < i_push.num) begin
                r_mem[r_wr + PBC_PTR_W'(k)] <= i_push.w[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd    <= '0;
            r_wr    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + PBC_PTR_W'(i_push.num);
            r_count <= r_count + PBC_CNT_W'(i_push.num) - PBC_CNT_W'(i_pop);
            if (i_pop) begin
                r_rd <= r_rd + PBC_PTR_W'(1);
            end
        end
    end

endmodule

### rtl/core/packet_block_check_core.sv
// Packet block check core: running 12-bit sum and reflected CRC-16 with printable check words.
// Takes one packet byte per cycle; sum and CRC update in the same cycle, and a zero byte
// ends the packet so later bytes are ignored until the last one. The last byte produces
// none, one, two or three check words (by check_type) into a four-entry result queue that
// drains one word per cycle while the output is not stalled. Input is stalled while the queue holds
// more than one word, so with the CRC check selected the queue has to drain back to one word
// before the next byte is taken. Configuration must be written by the user through the plain write
// port only while idle; the block itself does not enforce it.
module packet_block_check_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  pbc_pkg::t_in_word   i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output pbc_pkg::t_out_word  o_out_word,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [1:0]          i_cfg_data
);
    import pbc_pkg::*;

    logic                  in_accept;
    logic                  out_pop;
    t_push                 push;
    logic [PBC_CNT_W-1:0]  q_count;

    // room for a full set of check words must exist before a word is taken
    assign o_in_stall = (q_count > PBC_CNT_W'(PBC_FIFO_DEPTH - PBC_MAX_RES));
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_pop    = o_out_valid && !i_out_stall;

    pbc_check u_check (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (in_accept),
        .i_word     (i_in_word),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_push     (push)
    );

    pbc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (out_pop),
        .o_word  (o_out_word),
        .o_valid (o_out_valid),
        .o_count (q_count)
    );

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= PBC_CNT_W'(PBC_FIFO_DEPTH))
        else $error("result queue count above depth");

    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.num != '0) |=> o_out_valid)
        else $error("pushed check word not presented");

    a_push_only_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.num != '0) |-> (in_accept && i_in_word.last_byte))
        else $error("check words pushed without an accepted last byte");

endmodule
